>>> rtl/core/ppas_pkg.sv
// ---------------------------------------------------------------------------
// ppas_pkg
// Shared types and codes of the pick-and-place arm sequencer.
// ---------------------------------------------------------------------------
package ppas_pkg;

  localparam int TIME_BITS = 16;
  localparam int LIMIT_BITS = 16;
  localparam int SPEED_BITS = 8;
  localparam int CMP_BITS = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

  // request function
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // motor commands
  localparam logic [1:0] CMD_STOP = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_BWD  = 2'd2;

  // job actions
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PICK  = 2'd1;
  localparam logic [1:0] KIND_PLACE = 2'd2;

  // turn sides
  localparam logic [1:0] SIDE_FRONT = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_STARTED    = 3'd1;
  localparam logic [2:0] EV_TURN_DONE  = 3'd2;
  localparam logic [2:0] EV_LOWER_DONE = 3'd3;
  localparam logic [2:0] EV_CLAW_DONE  = 3'd4;
  localparam logic [2:0] EV_RAISE_DONE = 3'd5;
  localparam logic [2:0] EV_BACK_DONE  = 3'd6;
  localparam logic [2:0] EV_JOB_DONE   = 3'd7;

  // configuration register indexes
  localparam logic [2:0] REG_TURN_TIME   = 3'd0;
  localparam logic [2:0] REG_LOWER_TIME  = 3'd1;
  localparam logic [2:0] REG_CLOSE_TIME  = 3'd2;
  localparam logic [2:0] REG_OPEN_TIME   = 3'd3;
  localparam logic [2:0] REG_RAISE_TIME  = 3'd4;
  localparam logic [2:0] REG_DRIVE_SPEED = 3'd5;

  localparam logic [LIMIT_BITS-1:0] TIME_RESET  = LIMIT_BITS'(1000);
  localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(150);

  typedef struct packed {
    logic [LIMIT_BITS-1:0] turn_time;
    logic [LIMIT_BITS-1:0] lower_time;
    logic [LIMIT_BITS-1:0] close_time;
    logic [LIMIT_BITS-1:0] open_time;
    logic [LIMIT_BITS-1:0] raise_time;
    logic [SPEED_BITS-1:0] drive_speed;
  } ppas_cfg_t;

  typedef struct packed {
    logic                  func;
    logic [1:0]            action_kind;
    logic [1:0]            turn_side;
  } ppas_req_t;

  typedef struct packed {
    logic [1:0]            base_cmd;
    logic [1:0]            arm_cmd;
    logic [1:0]            claw_cmd;
    logic [SPEED_BITS-1:0] speed_out;
    logic [2:0]            event_code;
    logic                  busy_res;
  } ppas_res_t;

endpackage

>>> rtl/core/ppas_if.sv
// ---------------------------------------------------------------------------
// ppas_if
// Request, result and configuration channels of the arm sequencer.
// ---------------------------------------------------------------------------
interface ppas_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] action_kind;
  logic [1:0] turn_side;

  modport source (output valid, func, action_kind, turn_side, input ready);
  modport sink   (input valid, func, action_kind, turn_side, output ready);
endinterface

interface ppas_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] base_cmd;
  logic [1:0] arm_cmd;
  logic [1:0] claw_cmd;
  logic [7:0] speed_out;
  logic [2:0] event_code;
  logic       busy_res;

  modport source (output valid, base_cmd, arm_cmd, claw_cmd, speed_out, event_code,
                  busy_res, input ready);
  modport sink   (input valid, base_cmd, arm_cmd, claw_cmd, speed_out, event_code,
                  busy_res, output ready);
endinterface

interface ppas_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/core/ppas_cfg_regs.sv
// ---------------------------------------------------------------------------
// ppas_cfg_regs
// Phase time limits and drive speed, written through the config channel.
// ---------------------------------------------------------------------------
module ppas_cfg_regs
  import ppas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ppas_cfg_if.sink  cfg,
  output ppas_cfg_t regs
);

  ppas_cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign regs = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.turn_time   <= TIME_RESET;
      cfg_q.lower_time  <= TIME_RESET;
      cfg_q.close_time  <= TIME_RESET;
      cfg_q.open_time   <= TIME_RESET;
      cfg_q.raise_time  <= TIME_RESET;
      cfg_q.drive_speed <= SPEED_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_TURN_TIME:   cfg_q.turn_time   <= cfg.data[LIMIT_BITS-1:0];
        REG_LOWER_TIME:  cfg_q.lower_time  <= cfg.data[LIMIT_BITS-1:0];
        REG_CLOSE_TIME:  cfg_q.close_time  <= cfg.data[LIMIT_BITS-1:0];
        REG_OPEN_TIME:   cfg_q.open_time   <= cfg.data[LIMIT_BITS-1:0];
        REG_RAISE_TIME:  cfg_q.raise_time  <= cfg.data[LIMIT_BITS-1:0];
        REG_DRIVE_SPEED: cfg_q.drive_speed <= cfg.data[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/ppas_step.sv
// ---------------------------------------------------------------------------
// ppas_step
// Phase sequencer state and the per-request update and result logic.
// ---------------------------------------------------------------------------
module ppas_step
  import ppas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      go,
  input  ppas_req_t req,
  input  ppas_cfg_t regs,
  output ppas_res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TURN      = 3'd1,
    PH_LOWER     = 3'd2,
    PH_CLAW      = 3'd3,
    PH_RAISE     = 3'd4,
    PH_TURN_BACK = 3'd5,
    PH_DONE      = 3'd6
  } phase_t;

  phase_t               phase, phase_next;
  logic [TIME_BITS-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [1:0]           job_kind, job_kind_next;
  logic [1:0]           job_side, job_side_next;
  logic [1:0]           base_state, base_state_next;
  logic [1:0]           arm_state, arm_state_next;
  logic [1:0]           claw_state, claw_state_next;
  logic [2:0]           ev;
  logic [CMP_BITS-1:0]  el_cmp;

  assign elapsed_inc = (elapsed == {TIME_BITS{1'b1}}) ? elapsed : elapsed + 1'b1;
  assign el_cmp = CMP_BITS'(elapsed_inc);

  always_comb begin
    phase_next      = phase;
    elapsed_next    = elapsed;
    job_kind_next   = job_kind;
    job_side_next   = job_side;
    base_state_next = base_state;
    arm_state_next  = arm_state;
    claw_state_next = claw_state;
    ev              = EV_NONE;

    if (req.func == FUNC_START) begin
      job_kind_next   = req.action_kind;
      job_side_next   = req.turn_side;
      phase_next      = PH_TURN;
      elapsed_next    = '0;
      base_state_next = CMD_STOP;
      arm_state_next  = CMD_STOP;
      claw_state_next = CMD_STOP;
      ev              = EV_STARTED;
    end else begin
      case (phase)
        PH_IDLE: ;
        PH_TURN: begin
          elapsed_next = elapsed_inc;
          if (el_cmp > CMP_BITS'(regs.turn_time) || job_side == SIDE_FRONT) begin
            base_state_next = CMD_STOP;
            elapsed_next    = '0;
            ev              = EV_TURN_DONE;
            phase_next      = PH_LOWER;
          end else if (job_side == SIDE_LEFT) begin
            base_state_next = CMD_FWD;
          end else if (job_side == SIDE_RIGHT) begin
            base_state_next = CMD_BWD;
          end
        end
        PH_LOWER: begin
          elapsed_next = elapsed_inc;
          if (el_cmp > CMP_BITS'(regs.lower_time)) begin
            arm_state_next = CMD_STOP;
            elapsed_next   = '0;
            ev             = EV_LOWER_DONE;
            phase_next     = PH_CLAW;
          end else if (job_kind != KIND_NONE) begin
            arm_state_next = CMD_FWD;
          end
        end
        PH_CLAW: begin
          elapsed_next = elapsed_inc;
          // no claw action: phase ends on the first tick
          if ((job_kind == KIND_PICK && el_cmp > CMP_BITS'(regs.close_time)) ||
              (job_kind == KIND_PLACE && el_cmp > CMP_BITS'(regs.open_time)) ||
              (job_kind != KIND_PICK && job_kind != KIND_PLACE)) begin
            claw_state_next = CMD_STOP;
            elapsed_next    = '0;
            ev              = EV_CLAW_DONE;
            phase_next      = PH_RAISE;
          end else if (job_kind == KIND_PICK) begin
            claw_state_next = CMD_BWD;
          end else begin
            claw_state_next = CMD_FWD;
          end
        end
        PH_RAISE: begin
          elapsed_next = elapsed_inc;
          if (el_cmp > CMP_BITS'(regs.raise_time)) begin
            arm_state_next = CMD_STOP;
            elapsed_next   = '0;
            ev             = EV_RAISE_DONE;
            phase_next     = PH_TURN_BACK;
          end else if (job_kind != KIND_NONE) begin
            arm_state_next = CMD_BWD;
          end
        end
        PH_TURN_BACK: begin
          elapsed_next = elapsed_inc;
          if (el_cmp > CMP_BITS'(regs.turn_time) || job_side == SIDE_FRONT) begin
            base_state_next = CMD_STOP;
            elapsed_next    = '0;
            ev              = EV_BACK_DONE;
            phase_next      = PH_DONE;
          end else if (job_side == SIDE_LEFT) begin
            base_state_next = CMD_BWD;
          end else if (job_side == SIDE_RIGHT) begin
            base_state_next = CMD_FWD;
          end
        end
        PH_DONE: begin
          ev              = EV_JOB_DONE;
          job_kind_next   = KIND_NONE;
          phase_next      = PH_IDLE;
          elapsed_next    = '0;
          base_state_next = CMD_STOP;
          arm_state_next  = CMD_STOP;
          claw_state_next = CMD_STOP;
        end
        default: begin
          phase_next      = PH_IDLE;
          elapsed_next    = '0;
          base_state_next = CMD_STOP;
          arm_state_next  = CMD_STOP;
          claw_state_next = CMD_STOP;
        end
      endcase
    end
  end

  always_comb begin
    res.base_cmd   = base_state_next;
    res.arm_cmd    = arm_state_next;
    res.claw_cmd   = claw_state_next;
    res.speed_out  = ((base_state_next | arm_state_next | claw_state_next) != CMD_STOP) ?
                     regs.drive_speed : '0;
    res.event_code = ev;
    res.busy_res   = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      elapsed    <= '0;
      job_kind   <= KIND_NONE;
      job_side   <= SIDE_FRONT;
      base_state <= CMD_STOP;
      arm_state  <= CMD_STOP;
      claw_state <= CMD_STOP;
    end else if (go) begin
      phase      <= phase_next;
      elapsed    <= elapsed_next;
      job_kind   <= job_kind_next;
      job_side   <= job_side_next;
      base_state <= base_state_next;
      arm_state  <= arm_state_next;
      claw_state <= claw_state_next;
    end
  end

endmodule

>>> rtl/core/pick_place_arm_sequencer.sv
// A result is registered: each request passes the input register, then the
// result register, and waits in the input register while results are held.
// Throughput: one request per cycle while results are taken; the phase update
// and limit compare fit between the two registers.
// Reset (rst, synchronous): sequencer idle, motors stopped, limits 1000,
// drive speed 150, both pipeline registers empty.
// ---------------------------------------------------------------------------
// pick_place_arm_sequencer
// Timed five-phase pick-and-place sequencer for base, arm and claw motors.
// ---------------------------------------------------------------------------
module pick_place_arm_sequencer
  import ppas_pkg::*;
(
  input logic       clk,
  input logic       rst,
  ppas_req_if.sink  item,
  ppas_res_if.source result,
  ppas_cfg_if.sink  cfg
);

  ppas_cfg_t regs;
  ppas_req_t req_q;
  ppas_res_t res_comb, res_q;
  logic      req_valid;
  logic      res_valid;
  logic      advance;

  // request moves to the result register when that register is free or drains
  assign advance    = req_valid && (!res_valid || result.ready);
  assign item.ready = !req_valid || advance;

  ppas_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ppas_step u_step (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .req  (req_q),
    .regs (regs),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        req_valid <= item.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      req_q.func        <= item.func;
      req_q.action_kind <= item.action_kind;
      req_q.turn_side   <= item.turn_side;
    end
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign result.valid      = res_valid;
  assign result.base_cmd   = res_q.base_cmd;
  assign result.arm_cmd    = res_q.arm_cmd;
  assign result.claw_cmd   = res_q.claw_cmd;
  assign result.speed_out  = res_q.speed_out;
  assign result.event_code = res_q.event_code;
  assign result.busy_res   = res_q.busy_res;

endmodule

>>> dv/pick_place_arm_sequencer_tb.sv
// ---------------------------------------------------------------------------
// pick_place_arm_sequencer_tb
// Drives start and tick requests into the arm sequencer and checks every
// result against a cycle-free predictor of the phase sequencing. Covers
// aborts, side and action corner cases, limits near the counter maximum,
// and random jobs under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module pick_place_arm_sequencer_tb;
  import ppas_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TURN, PH_LOWER, PH_CLAW, PH_RAISE, PH_BACK, PH_DONE
  } arm_phase_t;

  localparam int STALL_LIMIT = 4000;

  class arm_scoreboard;
    ppas_cfg_t  regs;
    arm_phase_t phase;
    logic [15:0] elapsed;
    logic [1:0] kind, side, base_m, arm_m, claw_m;
    ppas_res_t  pending[$];
    int         errors;

    function new();
      regs.turn_time   = TIME_RESET;
      regs.lower_time  = TIME_RESET;
      regs.close_time  = TIME_RESET;
      regs.open_time   = TIME_RESET;
      regs.raise_time  = TIME_RESET;
      regs.drive_speed = SPEED_RESET;
      phase   = PH_IDLE;
      elapsed = '0;
      kind    = KIND_NONE;
      side    = SIDE_FRONT;
      base_m  = CMD_STOP;
      arm_m   = CMD_STOP;
      claw_m  = CMD_STOP;
      errors  = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_TURN_TIME:   regs.turn_time   = val;
        REG_LOWER_TIME:  regs.lower_time  = val;
        REG_CLOSE_TIME:  regs.close_time  = val;
        REG_OPEN_TIME:   regs.open_time   = val;
        REG_RAISE_TIME:  regs.raise_time  = val;
        REG_DRIVE_SPEED: regs.drive_speed = val[7:0];
        default: ;
      endcase
    endfunction

    // phase finished: clear the counter and step to the next phase
    function logic [2:0] advance(logic [2:0] ev_code);
      elapsed = '0;
      phase   = arm_phase_t'(phase + 3'd1);
      return ev_code;
    endfunction

    function void note_request(ppas_req_t r);
      ppas_res_t  res;
      logic [2:0] ev;
      ev = EV_NONE;
      if (r.func == FUNC_START) begin
        kind    = r.action_kind;
        side    = r.turn_side;
        phase   = PH_TURN;
        elapsed = '0;
        base_m  = CMD_STOP;
        arm_m   = CMD_STOP;
        claw_m  = CMD_STOP;
        ev      = EV_STARTED;
      end else begin
        if (phase >= PH_TURN && phase <= PH_BACK && elapsed != '1)
          elapsed = elapsed + 16'd1;
        case (phase)
          PH_TURN: begin
            if (elapsed > regs.turn_time || side == SIDE_FRONT) begin
              base_m = CMD_STOP;
              ev = advance(EV_TURN_DONE);
            end else if (side == SIDE_LEFT) base_m = CMD_FWD;
            else if (side == SIDE_RIGHT) base_m = CMD_BWD;
          end
          PH_LOWER: begin
            if (elapsed > regs.lower_time) begin
              arm_m = CMD_STOP;
              ev = advance(EV_LOWER_DONE);
            end else if (kind != KIND_NONE) arm_m = CMD_FWD;
          end
          PH_CLAW: begin
            if (kind == KIND_PICK) begin
              if (elapsed > regs.close_time) begin
                claw_m = CMD_STOP;
                ev = advance(EV_CLAW_DONE);
              end else claw_m = CMD_BWD;
            end else if (kind == KIND_PLACE) begin
              if (elapsed > regs.open_time) begin
                claw_m = CMD_STOP;
                ev = advance(EV_CLAW_DONE);
              end else claw_m = CMD_FWD;
            end else begin
              // no claw action: phase passes on the first tick
              claw_m = CMD_STOP;
              ev = advance(EV_CLAW_DONE);
            end
          end
          PH_RAISE: begin
            if (elapsed > regs.raise_time) begin
              arm_m = CMD_STOP;
              ev = advance(EV_RAISE_DONE);
            end else if (kind != KIND_NONE) arm_m = CMD_BWD;
          end
          PH_BACK: begin
            if (elapsed > regs.turn_time || side == SIDE_FRONT) begin
              base_m = CMD_STOP;
              ev = advance(EV_BACK_DONE);
            end else if (side == SIDE_LEFT) base_m = CMD_BWD;
            else if (side == SIDE_RIGHT) base_m = CMD_FWD;
          end
          PH_DONE: begin
            ev      = EV_JOB_DONE;
            kind    = KIND_NONE;
            phase   = PH_IDLE;
            elapsed = '0;
            base_m  = CMD_STOP;
            arm_m   = CMD_STOP;
            claw_m  = CMD_STOP;
          end
          PH_IDLE: ;
          default: begin
            phase   = PH_IDLE;
            elapsed = '0;
            base_m  = CMD_STOP;
            arm_m   = CMD_STOP;
            claw_m  = CMD_STOP;
          end
        endcase
      end
      res.base_cmd   = base_m;
      res.arm_cmd    = arm_m;
      res.claw_cmd   = claw_m;
      res.speed_out  = ((base_m | arm_m | claw_m) != 2'd0) ? regs.drive_speed : '0;
      res.event_code = ev;
      res.busy_res   = (phase != PH_IDLE);
      pending.push_back(res);
    endfunction

    function void check_result(ppas_res_t got);
      ppas_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: base %0d arm %0d claw %0d speed %0d ev %0d busy %0d",
                   $time, got.base_cmd, got.arm_cmd, got.claw_cmd, got.speed_out,
                   got.event_code, got.busy_res);
        return;
      end
      want = pending.pop_front();
      if (got.base_cmd !== want.base_cmd || got.arm_cmd !== want.arm_cmd ||
          got.claw_cmd !== want.claw_cmd || got.speed_out !== want.speed_out ||
          got.event_code !== want.event_code || got.busy_res !== want.busy_res) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] result mismatch (expected / actual)", $time);
          $display("  base %0d / %0d  arm %0d / %0d  claw %0d / %0d",
                   want.base_cmd, got.base_cmd, want.arm_cmd, got.arm_cmd,
                   want.claw_cmd, got.claw_cmd);
          $display("  speed %0d / %0d  event %0d / %0d  busy %0d / %0d",
                   want.speed_out, got.speed_out, want.event_code, got.event_code,
                   want.busy_res, got.busy_res);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ppas_req_if item_ch ();
  ppas_res_if res_ch ();
  ppas_cfg_if cfg_ch ();

  pick_place_arm_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  arm_scoreboard sb = new();

  int burst_left;
  bit valid_up;
  bit fast_send;
  bit hold_req;
  int hold_left;
  int rx_cycle;
  int rx_mode;
  int quiet_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver: check accepted results, stall on a shifting pattern
  always @(posedge clk) begin : rx_side
    ppas_res_t got;
    if (res_ch.valid && res_ch.ready) begin
      got.base_cmd   = res_ch.base_cmd;
      got.arm_cmd    = res_ch.arm_cmd;
      got.claw_cmd   = res_ch.claw_cmd;
      got.speed_out  = res_ch.speed_out;
      got.event_code = res_ch.event_code;
      got.busy_res   = res_ch.busy_res;
      sb.check_result(got);
    end
    rx_cycle++;
    if (hold_req) begin
      hold_left = $urandom_range(80, 120);
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= $urandom_range(0, 1);
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (rx_cycle % 3 != 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input ppas_req_t r);
    item_ch.valid       <= 1'b1;
    item_ch.func        <= r.func;
    item_ch.action_kind <= r.action_kind;
    item_ch.turn_side   <= r.turn_side;
    valid_up = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_request(r);
    if (!fast_send) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        item_ch.valid <= 1'b0;
        valid_up = 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                 : $urandom_range(0, 12);
      end
    end
  endtask

  task automatic send_ticks(input int n);
    ppas_req_t r;
    for (int i = 0; i < n; i++) begin
      r.func        = FUNC_TICK;
      r.action_kind = $urandom_range(0, 3);
      r.turn_side   = $urandom_range(0, 3);
      send_req(r);
    end
  endtask

  task automatic run_job(input logic [1:0] kind, input logic [1:0] side, input int ticks);
    ppas_req_t r;
    r.func        = FUNC_START;
    r.action_kind = kind;
    r.turn_side   = side;
    send_req(r);
    send_ticks(ticks);
  endtask

  task automatic drain_results();
    if (valid_up) begin
      item_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (sb.pending.size() != 0) @(posedge clk);
    // two-stage pipeline: let it empty before touching registers
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(input logic [15:0] t_turn, input logic [15:0] t_lower,
                           input logic [15:0] t_close, input logic [15:0] t_open,
                           input logic [15:0] t_raise, input logic [15:0] spd);
    write_reg(REG_TURN_TIME, t_turn);
    write_reg(REG_LOWER_TIME, t_lower);
    write_reg(REG_CLOSE_TIME, t_close);
    write_reg(REG_OPEN_TIME, t_open);
    write_reg(REG_RAISE_TIME, t_raise);
    write_reg(REG_DRIVE_SPEED, spd);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_time();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 16'd0;
    if (r < 12) return 16'($urandom_range(1, 4));
    if (r < 18) return 16'($urandom_range(5, 12));
    return 16'($urandom_range(13, 40));
  endfunction

  // ticks that carry a job from start through done
  function automatic int job_ticks();
    int claw_t;
    claw_t = (sb.regs.close_time > sb.regs.open_time) ? int'(sb.regs.close_time)
                                                       : int'(sb.regs.open_time);
    return 2 * (int'(sb.regs.turn_time) + 1) + int'(sb.regs.lower_time) + 1 +
           claw_t + 1 + int'(sb.regs.raise_time) + 1 + 1;
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 9);
    return (r < 3) ? KIND_PICK : (r < 6) ? KIND_PLACE : (r < 8) ? KIND_NONE : 2'd3;
  endfunction

  function automatic logic [1:0] pick_side();
    int r;
    r = $urandom_range(0, 9);
    return (r < 3) ? SIDE_LEFT : (r < 6) ? SIDE_RIGHT : (r < 8) ? SIDE_FRONT : 2'd3;
  endfunction

  initial begin
    int jobs;
    int busy_reqs;
    int budget;
    int r;
    item_ch.valid       = 1'b0;
    item_ch.func        = FUNC_TICK;
    item_ch.action_kind = KIND_NONE;
    item_ch.turn_side   = SIDE_FRONT;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = REG_TURN_TIME;
    cfg_ch.data         = '0;
    rst          = 1'b1;
    burst_left   = 0;
    valid_up     = 1'b0;
    fast_send    = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;
    rx_cycle     = 0;
    rx_mode      = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tick while idle, then a job under reset limits, motors at reset speed
    send_ticks(1);
    run_job(KIND_PICK, SIDE_LEFT, 3);
    drain_results();

    write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'hFFFF);
    // place to the right aborts the pending pick job
    run_job(KIND_PLACE, SIDE_RIGHT, job_ticks() + 1);
    run_job(KIND_NONE, SIDE_FRONT, job_ticks());
    run_job(2'd3, 2'd3, 6);
    drain_results();

    // limit at counter max: the turn phase keeps running
    fast_send = 1'b1;
    write_all(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'h00FF);
    run_job(KIND_PICK, SIDE_LEFT, 60);
    drain_results();
    // limit one below max: the arm keeps moving down
    write_all(16'd0, 16'hFFFE, 16'd0, 16'hFFFF, 16'd0, 16'h5A00);
    run_job(KIND_PICK, SIDE_FRONT, 45);
    drain_results();
    fast_send = 1'b0;

    jobs = 0;
    busy_reqs = 0;
    while (busy_reqs < 1150) begin
      if (jobs % 12 == 0) begin
        drain_results();
        write_all(pick_time(), pick_time(), pick_time(), pick_time(), pick_time(),
                  16'($urandom));
      end
      if (jobs == 3) hold_req = 1'b1;
      budget = job_ticks();
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_ticks($urandom_range(1, 4));
      end else if (r == 1) begin
        budget = $urandom_range(0, budget - 1);
        run_job(pick_kind(), pick_side(), budget);
        busy_reqs += budget + 1;
      end else begin
        budget += $urandom_range(0, 2);
        run_job(pick_kind(), pick_side(), budget);
        busy_reqs += budget + 1;
      end
      jobs++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ppas_pkg.sv
rtl/core/ppas_if.sv
rtl/core/ppas_cfg_regs.sv
rtl/core/ppas_step.sv
rtl/core/pick_place_arm_sequencer.sv
dv/pick_place_arm_sequencer_tb.sv
